>>> rtl/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

  // Pattern storage: four 64-bit words, little-endian byte packing.
  localparam int PAT_MAX    = 32;
  localparam int PAT_IDX_W  = 5;
  localparam int PAT_WORDS  = 4;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Pattern length register.
  localparam int LEN_W = 6;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd16;

  // Result field widths.
  localparam int OFF_W  = 32;
  localparam int ADDR_W = 64;

  // Result queue between the search pipeline and the output port.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  typedef logic [7:0] byte_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4,
    REG_BASE = 3'd5
  } cfg_reg_e;

  // One result beat.
  typedef struct packed {
    logic              found;
    logic [OFF_W-1:0]  offset;
    logic [ADDR_W-1:0] address;
  } result_t;

endpackage

>>> rtl/byte_pattern_search.sv
`timescale 1ns / 1ps

// A result beat passes the result stage register and then the result queue to the output.
// Throughput: one input beat per cycle; input stalls only while three results wait unread.
// The window compare is a row of one-byte cells, so the pace does not depend on the length.
// Reset: configuration returns to its reset values (length 16) and the search state clears;
// the window bytes themselves are not reset and are only compared once refilled.

module byte_pattern_search import bps_pkg::*; #(
  parameter int WINDOW_BYTES = 32,
  parameter int COUNT_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [OFF_W-1:0]      match_offset_o,
  output logic [ADDR_W-1:0]     match_address_o
);

  localparam int CAP = (WINDOW_BYTES < PAT_MAX) ? WINDOW_BYTES : PAT_MAX;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

  // Configuration registers.
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pattern_q;
  logic [LEN_W-1:0]                     length_q;
  logic [ADDR_W-1:0]                    base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LEN_RESET;
      base_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PAT0: pattern_q[0] <= cfg_wdata_i;
        REG_PAT1: pattern_q[1] <= cfg_wdata_i;
        REG_PAT2: pattern_q[2] <= cfg_wdata_i;
        REG_PAT3: pattern_q[3] <= cfg_wdata_i;
        REG_LEN:  length_q     <= cfg_wdata_i[LEN_W-1:0];
        REG_BASE: base_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective length: zero counts as one; the smaller of window size and PAT_MAX caps it.
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    eff_len = length_q;
    if (length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (length_q > CAP_LEN) begin
      eff_len = CAP_LEN;
    end
  end

  logic [PAT_MAX-1:0][7:0] pat_bytes;
  assign pat_bytes = pattern_q;

  // Handshake and search state.
  logic                  accept;
  logic                  shift_en;
  logic                  match_done_q, match_done_d;
  logic [COUNT_BITS-1:0] bytes_seen_q, bytes_seen_d;

  assign accept   = in_valid_i && in_ready_o;
  assign shift_en = accept && !match_done_q;

  // Window as a chain of cells; cell k holds the k-th newest byte and
  // is compared with pattern byte (length - 1 - k).
  byte_t                   win_byte [WINDOW_BYTES];
  byte_t                   cell_in  [WINDOW_BYTES];
  byte_t                   cell_exp [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] cell_match;
  logic [WINDOW_BYTES-1:0] cell_used;

  for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_cell
    logic [LEN_W-1:0] pat_idx;

    if (k == 0) begin : g_head
      assign cell_in[k] = data_byte_i;
    end else begin : g_link
      assign cell_in[k] = win_byte[k-1];
    end

    assign pat_idx     = eff_len - LEN_W'(k + 1);
    assign cell_exp[k] = pat_bytes[pat_idx[PAT_IDX_W-1:0]];
    assign cell_used[k] = (eff_len > LEN_W'(k));

    bps_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en),
      .byte_i     (cell_in[k]),
      .expect_i   (cell_exp[k]),
      .byte_o     (win_byte[k]),
      .match_o    (cell_match[k])
    );
  end

  // Saturating byte count and the match decision on the updated window.
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] len_ext;
  logic [COUNT_BITS-1:0] off_full;
  logic [OFF_W-1:0]      off_sat;
  logic                  hit;

  assign cnt_inc  = (bytes_seen_q == '1) ? bytes_seen_q
                                         : bytes_seen_q + COUNT_BITS'(1);
  assign len_ext  = COUNT_BITS'(eff_len);
  assign hit      = (cnt_inc >= len_ext) && (&(cell_match | ~cell_used));
  assign off_full = cnt_inc - len_ext;

  if (COUNT_BITS > OFF_W) begin : g_off_wide
    assign off_sat = (|off_full[COUNT_BITS-1:OFF_W]) ? '1 : off_full[OFF_W-1:0];
  end else begin : g_off_narrow
    assign off_sat = OFF_W'(off_full);
  end

  // Result stage: holds the decision of the beat accepted last cycle.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_found_q, s1_found_d;
  logic [OFF_W-1:0] s1_off_q, s1_off_d;

  always_comb begin
    match_done_d = match_done_q;
    bytes_seen_d = bytes_seen_q;
    s1_valid_d   = 1'b0;
    s1_found_d   = hit;
    s1_off_d     = hit ? off_sat : '0;
    if (accept) begin
      if (match_done_q) begin
        // Bytes after a match are dropped; the last one ends the region.
        if (last_byte_i) begin
          match_done_d = 1'b0;
          bytes_seen_d = '0;
        end
      end else begin
        s1_valid_d = hit || last_byte_i;
        if (last_byte_i) begin
          match_done_d = 1'b0;
          bytes_seen_d = '0;
        end else begin
          match_done_d = hit;
          bytes_seen_d = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_done_q <= 1'b0;
      bytes_seen_q <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      match_done_q <= match_done_d;
      bytes_seen_q <= bytes_seen_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_found_q <= s1_found_d;
    s1_off_q   <= s1_off_d;
  end

  // Address add and result queue.
  result_t               push_res;
  result_t               head_res;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   occupancy;

  assign push_res.found   = s1_found_q;
  assign push_res.offset  = s1_off_q;
  assign push_res.address = s1_found_q ? (base_q + ADDR_W'(s1_off_q)) : '0;

  bps_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_res),
    .pop_ready_i (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (head_res),
    .count_o     (fifo_cnt)
  );

  // Take a beat only while the queue has room for one more result in flight.
  assign occupancy  = {1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(s1_valid_q);
  assign in_ready_o = (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

  assign found_o         = head_res.found;
  assign match_offset_o  = head_res.offset;
  assign match_address_o = head_res.address;

  // A beat with the last-byte flag always leaves a clean search state.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_byte_i) |=> ((bytes_seen_q == '0) && !match_done_q))
    else $error("search state not cleared after last byte");

  // The result stage only fills from a beat accepted the cycle before.
  a_s1_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(accept))
    else $error("result without an accepted beat");

  // Entering the matched state always comes with a found result.
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(match_done_q) |-> (s1_valid_q && s1_found_q))
    else $error("match recorded without a result");

  // A not-found result carries a zero offset.
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_found_q) |-> (s1_off_q == '0))
    else $error("not-found result with nonzero offset");

endmodule

>>> rtl/bps_cell.sv
`timescale 1ns / 1ps

module bps_cell import bps_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_en_i,
  input  byte_t byte_i,
  input  byte_t expect_i,
  output byte_t byte_o,
  output logic  match_o
);

  byte_t byte_q;

  // Hold one window byte; it moves on to the next cell on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // Compare the byte that this cell takes in now, i.e. the updated window.
  assign match_o = (byte_i == expect_i);

endmodule

>>> rtl/bps_out_fifo.sv
`timescale 1ns / 1ps

module bps_out_fifo import bps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               push_data_i,
  input  logic                  pop_ready_i,
  output logic                  valid_o,
  output result_t               data_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] FULL_CNT = FIFO_CNT_W'(FIFO_DEPTH);

  result_t                 entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  // Pointer and fill count update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The upstream stall rule must leave room for every result in flight.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ((count_q != FULL_CNT) || pop))
    else $error("result queue overflow");

endmodule
